// File: rtl/flsm_pkg.sv
// ----------------------------------------------------------------------------
// flsm_pkg
// Types and codes shared by the flash log slot manager.
// ----------------------------------------------------------------------------
package flsm_pkg;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 3;
    localparam int EPOCH_W  = 32;

    localparam logic [EPOCH_W-1:0] EMPTY_EPOCH = 32'hFFFF_FFFF;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RECORD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REPLAY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RETRY  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_WRITE = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_READ  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_BELOW = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NONE  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_LOAD  = 3'd4;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LD_RD,
        ST_LD_WR,
        ST_REC_DIV,
        ST_REC_CHK,
        ST_ER_RD,
        ST_ER_WR,
        ST_REC_WR,
        ST_RP_THR,
        ST_SC_RD,
        ST_SC_CHK,
        ST_DONE
    } state_t;

endpackage

// File: rtl/flash_log_slot_manager_core.sv
// ----------------------------------------------------------------------------
// flash_log_slot_manager_core
// Slot bookkeeping of a circular flash log: load pass, write slot with sector
// erase handling, and bit-reversed replay scan over a valid map memory.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+--------------------
//  input   | s_mode, s_slot_index, s_epoch           | s_valid / s_ready
//  result  | m_status, m_slot, m_erase_needed,       | m_valid / m_ready
//          | m_sector_first_slot, m_valid_count      |
//  config  | cfg_wr_data (replay threshold)          | cfg_wr_en
//
//  After reset a clearing pass zeroes the valid map. Load reads the slot's
//  mark, then writes it. Record finds the sector, checks the write slot and,
//  on erase, clears each slot from there to the sector end before the write.
//  Replay checks the threshold; replay and retry then read the valid map once
//  per slot scanned. One transaction in flight; a pending result stalls only
//  the final step; the next one may be accepted while the result waits at the output.
// ----------------------------------------------------------------------------
module flash_log_slot_manager_core #(
    parameter int SLOT_INDEX_BITS  = 10,
    parameter int SLOTS_PER_SECTOR = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [SLOT_INDEX_BITS:0]              cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [flsm_pkg::MODE_W-1:0]           s_mode,
    input  logic [SLOT_INDEX_BITS-1:0]            s_slot_index,
    input  logic [flsm_pkg::EPOCH_W-1:0]          s_epoch,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [flsm_pkg::STATUS_W-1:0]         m_status,
    output logic [SLOT_INDEX_BITS-1:0]            m_slot,
    output logic                                  m_erase_needed,
    output logic [SLOT_INDEX_BITS-1:0]            m_sector_first_slot,
    output logic [SLOT_INDEX_BITS:0]              m_valid_count
);
    import flsm_pkg::*;

    localparam int N          = SLOT_INDEX_BITS;
    localparam int CNT_W      = N + 1;
    localparam int SLOT_COUNT = 1 << N;
    localparam int SEC_L      = $clog2(SLOTS_PER_SECTOR);
    localparam int RCP_K      = N + SEC_L;
    localparam int RCP_W      = N + 2;
    localparam int PROD_W     = N + RCP_W;
    localparam int SEC_W      = $clog2(SLOTS_PER_SECTOR + 1);
    localparam int FW         = N + SEC_W;
    localparam int EW         = CNT_W + 10;
    localparam logic [RCP_W-1:0] RCP_M =
        RCP_W'(((1 << RCP_K) + SLOTS_PER_SECTOR - 1) / SLOTS_PER_SECTOR);

    state_t state_reg, state_next;

    logic                 valid_mem [SLOT_COUNT];
    logic                 rd_data_reg;
    logic [N-1:0]         rd_addr;
    logic                 mem_we;
    logic [N-1:0]         mem_waddr;
    logic                 mem_wdata;

    logic [CNT_W-1:0]     thr_reg;
    logic [N-1:0]         sidx_reg, sidx_next;
    logic [EPOCH_W-1:0]   epoch_reg, epoch_next;
    logic [N-1:0]         wp_reg, wp_next;
    logic [N-1:0]         rp_reg, rp_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic [CNT_W-1:0]     budget_reg, budget_next;
    logic [EPOCH_W-1:0]   hi_epoch_reg, hi_epoch_next;
    logic [N-1:0]         sweep_reg, sweep_next;
    logic [CNT_W-1:0]     end_reg, end_next;
    logic                 erase_reg, erase_next;
    logic [N-1:0]         first_reg, first_next;

    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [N-1:0]         res_slot_reg, res_slot_next;

    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [N-1:0]         m_slot_reg, m_slot_next;
    logic                 m_erase_reg, m_erase_next;
    logic [N-1:0]         m_first_reg, m_first_next;
    logic [CNT_W-1:0]     m_count_reg, m_count_next;

    logic [N-1:0]         rp_rev;
    logic [PROD_W-1:0]    quo_prod;
    logic [N-1:0]         sec_quo;
    logic [N-1:0]         first_calc;
    logic [EW-1:0]        end_sum;
    logic                 s_acc;
    logic                 out_free;
    logic                 ld_valid;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign ld_valid = (epoch_reg != EMPTY_EPOCH);

    always_comb begin
        for (int i = 0; i < N; i++) begin
            rp_rev[i] = rp_reg[N-1-i];
        end
    end

    // sector of the write pointer by reciprocal multiplication
    assign quo_prod   = PROD_W'(wp_reg) * PROD_W'(RCP_M);
    assign sec_quo    = N'(quo_prod >> RCP_K);
    assign first_calc = N'(FW'(sec_quo) * FW'(SLOTS_PER_SECTOR));

    assign end_sum = EW'(first_reg) + EW'(SLOTS_PER_SECTOR);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sweep_reg == {N{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_mode)
                        MODE_LOAD:   state_next = ST_LD_RD;
                        MODE_RECORD: state_next = ST_REC_DIV;
                        MODE_REPLAY: state_next = ST_RP_THR;
                        MODE_RETRY:  state_next = ST_SC_RD;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LD_RD:   state_next = ST_LD_WR;
            ST_LD_WR:   state_next = ST_DONE;
            ST_REC_DIV: state_next = ST_REC_CHK;
            ST_REC_CHK: state_next = rd_data_reg ? ST_ER_RD : ST_REC_WR;
            ST_ER_RD:   state_next = ST_ER_WR;
            ST_ER_WR: begin
                if ((CNT_W'(sweep_reg) + CNT_W'(1)) >= end_reg) begin
                    state_next = ST_REC_WR;
                end else begin
                    state_next = ST_ER_RD;
                end
            end
            ST_REC_WR:  state_next = ST_DONE;
            ST_RP_THR:  state_next = (total_reg < thr_reg) ? ST_DONE : ST_SC_RD;
            ST_SC_RD: begin
                if (budget_reg >= CNT_W'(SLOT_COUNT)) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SC_CHK;
                end
            end
            ST_SC_CHK:  state_next = rd_data_reg ? ST_DONE : ST_SC_RD;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        sidx_next       = sidx_reg;
        epoch_next      = epoch_reg;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        total_next      = total_reg;
        budget_next     = budget_reg;
        hi_epoch_next   = hi_epoch_reg;
        sweep_next      = sweep_reg;
        end_next        = end_reg;
        erase_next      = erase_reg;
        first_next      = first_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        m_erase_next    = m_erase_reg;
        m_first_next    = m_first_reg;
        m_count_next    = m_count_reg;
        rd_addr         = wp_reg;
        mem_we          = 1'b0;
        mem_waddr       = sweep_reg;
        mem_wdata       = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                sweep_next = sweep_reg + N'(1);
            end
            ST_IDLE: begin
                if (s_acc) begin
                    sidx_next    = s_slot_index;
                    epoch_next   = s_epoch;
                    erase_next   = 1'b0;
                    first_next   = '0;
                end
            end
            ST_LD_RD: begin
                rd_addr = sidx_reg;
            end
            ST_LD_WR: begin
                mem_we    = 1'b1;
                mem_waddr = sidx_reg;
                mem_wdata = ld_valid;
                if (ld_valid && !rd_data_reg) begin
                    total_next = total_reg + CNT_W'(1);
                end else if (!ld_valid && rd_data_reg) begin
                    total_next = total_reg - CNT_W'(1);
                end
                if (ld_valid && (epoch_reg >= hi_epoch_reg)) begin
                    hi_epoch_next = epoch_reg;
                    wp_next       = sidx_reg + N'(1);
                end
                res_status_next = STATUS_LOAD;
                res_slot_next   = sidx_reg;
            end
            ST_REC_DIV: begin
                first_next = first_calc;
            end
            ST_REC_CHK: begin
                erase_next = rd_data_reg;
                sweep_next = wp_reg;
                end_next   = (end_sum > EW'(SLOT_COUNT)) ? CNT_W'(SLOT_COUNT)
                                                         : CNT_W'(end_sum);
            end
            ST_ER_RD: begin
                rd_addr = sweep_reg;
            end
            ST_ER_WR: begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                mem_wdata = 1'b0;
                if (rd_data_reg) begin
                    total_next = total_reg - CNT_W'(1);
                end
                sweep_next = sweep_reg + N'(1);
            end
            ST_REC_WR: begin
                mem_we          = 1'b1;
                mem_waddr       = wp_reg;
                mem_wdata       = 1'b1;
                total_next      = total_reg + CNT_W'(1);
                wp_next         = wp_reg + N'(1);
                res_status_next = STATUS_WRITE;
                res_slot_next   = wp_reg;
            end
            ST_RP_THR: begin
                if (total_reg < thr_reg) begin
                    budget_next     = CNT_W'(SLOT_COUNT);
                    res_status_next = STATUS_BELOW;
                    res_slot_next   = '0;
                end else begin
                    budget_next = '0;
                end
            end
            ST_SC_RD: begin
                rd_addr = rp_rev;
                if (budget_reg >= CNT_W'(SLOT_COUNT)) begin
                    budget_next     = CNT_W'(SLOT_COUNT);
                    res_status_next = STATUS_NONE;
                    res_slot_next   = '0;
                end
            end
            ST_SC_CHK: begin
                rp_next     = rp_reg + N'(1);
                budget_next = budget_reg + CNT_W'(1);
                if (rd_data_reg) begin
                    res_status_next = STATUS_READ;
                    res_slot_next   = rp_rev;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_slot_next   = res_slot_reg;
                    m_erase_next  = erase_reg;
                    m_first_next  = first_reg;
                    m_count_next  = total_reg;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            valid_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= valid_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            thr_reg      <= CNT_W'(1);
            wp_reg       <= '0;
            rp_reg       <= '0;
            total_reg    <= '0;
            budget_reg   <= '0;
            hi_epoch_reg <= '0;
            sweep_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            total_reg    <= total_next;
            budget_reg   <= budget_next;
            hi_epoch_reg <= hi_epoch_next;
            sweep_reg    <= sweep_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sidx_reg       <= sidx_next;
        epoch_reg      <= epoch_next;
        end_reg        <= end_next;
        erase_reg      <= erase_next;
        first_reg      <= first_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
        m_erase_reg    <= m_erase_next;
        m_first_reg    <= m_first_next;
        m_count_reg    <= m_count_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = m_status_reg;
    assign m_slot              = m_slot_reg;
    assign m_erase_needed      = m_erase_reg;
    assign m_sector_first_slot = m_first_reg;
    assign m_valid_count       = m_count_reg;

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CNT_W'(SLOT_COUNT))
        else $error("valid count above slot count");

    a_budget_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        budget_reg <= CNT_W'(SLOT_COUNT))
        else $error("scan budget above one pass");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready while a transaction is in flight");

    a_sweep_in_sector: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ER_WR) |-> (CNT_W'(sweep_reg) < end_reg))
        else $error("erase sweep past sector end");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for flash_log_slot_manager_core. A behavioral copy of the
// slot policy predicts every result; directed cases cover the empty log, load
// pass corner cases, sector erase and wrap, threshold limits and the replay
// scan, then randomized load/record/replay sessions run with bursty input,
// receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import flsm_pkg::*;

    localparam int SLOT_BITS      = 10;
    localparam int SECTOR         = 16;
    localparam int SLOT_CNT       = 1 << SLOT_BITS;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_HALF    = 250;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [SLOT_BITS-1:0] slot;
        logic                 erase;
        logic [SLOT_BITS-1:0] first_slot;
        logic [SLOT_BITS:0]   count;
    } slot_result_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [SLOT_BITS:0]   cfg_wr_data = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [MODE_W-1:0]    s_mode       = MODE_LOAD;
    logic [SLOT_BITS-1:0] s_slot_index = '0;
    logic [EPOCH_W-1:0]   s_epoch      = '0;
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    logic [STATUS_W-1:0]  m_status;
    logic [SLOT_BITS-1:0] m_slot;
    logic                 m_erase_needed;
    logic [SLOT_BITS-1:0] m_sector_first_slot;
    logic [SLOT_BITS:0]   m_valid_count;

    // shadow copy of the slot bookkeeping
    logic                 valid_marks [0:SLOT_CNT-1];
    logic [SLOT_BITS-1:0] write_ptr;
    logic [SLOT_BITS-1:0] read_pos;
    int unsigned          marked_slots;
    int unsigned          scan_used;
    logic [EPOCH_W-1:0]   top_epoch;
    logic [SLOT_BITS:0]   replay_min;

    slot_result_t pending_results[$];

    int  items_sent      = 0;
    int  mismatches      = 0;
    int  thresholds_used = 0;
    int  status_hits [0:7];
    int  erase_hits      = 0;
    int  idle_cycles     = 0;
    int  burst_left      = 0;
    bit  send_gaps       = 1'b0;
    int  stall_mode      = 0;
    bit  hold_request    = 1'b0;
    int  hold_left       = 0;
    int  round_no        = 0;
    logic [7:0] ready_pat = 8'hFF;
    int  pat_cnt          = 0;
    logic [EPOCH_W-1:0] epoch_base;

    flash_log_slot_manager_core #(
        .SLOT_INDEX_BITS  (SLOT_BITS),
        .SLOTS_PER_SECTOR (SECTOR)
    ) u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_mode              (s_mode),
        .s_slot_index        (s_slot_index),
        .s_epoch             (s_epoch),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_slot              (m_slot),
        .m_erase_needed      (m_erase_needed),
        .m_sector_first_slot (m_sector_first_slot),
        .m_valid_count       (m_valid_count)
    );

    always #5 aclk = ~aclk;

    function automatic logic [SLOT_BITS-1:0] slot_bit_rev(input logic [SLOT_BITS-1:0] x);
        logic [SLOT_BITS-1:0] r;
        int b;
        for (b = 0; b < SLOT_BITS; b++) begin
            r[b] = x[SLOT_BITS-1-b];
        end
        return r;
    endfunction

    function automatic void set_valid_mark(input int s, input logic v);
        if (valid_marks[s] && !v) begin
            marked_slots--;
        end else if (!valid_marks[s] && v) begin
            marked_slots++;
        end
        valid_marks[s] = v;
    endfunction

    function automatic slot_result_t predict_slot_step(input logic [MODE_W-1:0] mode,
                                                       input logic [SLOT_BITS-1:0] idx,
                                                       input logic [EPOCH_W-1:0] ep);
        slot_result_t r;
        logic [SLOT_BITS-1:0] wp;
        int first, stop, s;
        bit go;
        r  = '0;
        go = 1'b1;
        case (mode)
            MODE_LOAD: begin
                set_valid_mark(int'(idx), ep != EMPTY_EPOCH);
                if (ep != EMPTY_EPOCH && ep >= top_epoch) begin
                    top_epoch = ep;
                    write_ptr = idx + 1'b1;
                end
                r.status = STATUS_LOAD;
                r.slot   = idx;
            end
            MODE_RECORD: begin
                wp    = write_ptr;
                first = int'(wp) - (int'(wp) % SECTOR);
                stop  = first + SECTOR;
                if (stop > SLOT_CNT) begin
                    stop = SLOT_CNT;
                end
                r.erase      = valid_marks[wp];
                r.first_slot = SLOT_BITS'(first);
                if (r.erase) begin
                    for (s = int'(wp); s < stop; s++) begin
                        set_valid_mark(s, 1'b0);
                    end
                end
                set_valid_mark(int'(wp), 1'b1);
                write_ptr = wp + 1'b1;
                r.status  = STATUS_WRITE;
                r.slot    = wp;
            end
            default: begin
                if (mode == MODE_REPLAY) begin
                    if (marked_slots < replay_min) begin
                        scan_used = SLOT_CNT;
                        r.status  = STATUS_BELOW;
                        go        = 1'b0;
                    end else begin
                        scan_used = 0;
                    end
                end
                if (go) begin
                    while (scan_used < SLOT_CNT && !valid_marks[slot_bit_rev(read_pos)]) begin
                        read_pos++;
                        scan_used++;
                    end
                    if (scan_used >= SLOT_CNT) begin
                        scan_used = SLOT_CNT;
                        r.status  = STATUS_NONE;
                    end else begin
                        r.slot   = slot_bit_rev(read_pos);
                        read_pos++;
                        scan_used++;
                        r.status = STATUS_READ;
                    end
                end
            end
        endcase
        r.count = (SLOT_BITS+1)'(marked_slots);
        return r;
    endfunction

    // one transaction on the input channel, with burst/gap pacing
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [SLOT_BITS-1:0] idx,
                             input logic [EPOCH_W-1:0] ep);
        int gap;
        gap = 0;
        if (send_gaps && burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = $urandom_range(1, 12);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_slot_index <= idx;
        s_epoch      <= ep;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_slot_step(mode, idx, ep));
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [SLOT_BITS:0] value);
        drain_results();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        replay_min = value;
        thresholds_used++;
    endtask

    task automatic test_empty_log();
        // retry straight after reset scans the whole empty map
        send_item(MODE_RETRY, '0, '0);
        send_item(MODE_REPLAY, '1, EMPTY_EPOCH);
        // refused replay exhausts the budget
        send_item(MODE_RETRY, '0, '0);
        write_threshold('0);
        send_item(MODE_REPLAY, '0, '0);
    endtask

    task automatic test_load_pass();
        send_item(MODE_LOAD, 10'd0, 32'hFFFF_FFFE);
        send_item(MODE_LOAD, 10'd1, EMPTY_EPOCH);
        send_item(MODE_LOAD, 10'd2, 32'h0000_0000);
        send_item(MODE_LOAD, 10'd3, 32'h8000_0001);
        // reload drops the mark, highest epoch stays
        send_item(MODE_LOAD, 10'd3, EMPTY_EPOCH);
        send_item(MODE_LOAD, 10'h2AA, 32'h5555_AAAA);
    endtask

    task automatic test_record();
        // slot 1 records without erase; slot 2 holds a mark, so its record erases
        send_item(MODE_RECORD, '0, '0);
        send_item(MODE_RECORD, '0, '0);
        send_item(MODE_LOAD, 10'd1023, 32'hFFFF_FFFE);
        send_item(MODE_RECORD, '1, '1);
        send_item(MODE_LOAD, 10'd1022, 32'hFFFF_FFFE);
        // last slot of the map, then wrap to slot 0
        send_item(MODE_RECORD, '0, '0);
        send_item(MODE_RECORD, '0, '0);
    endtask

    task automatic test_replay();
        write_threshold(11'd1);
        send_item(MODE_REPLAY, '0, '0);
        send_item(MODE_RETRY, '0, '0);
        send_item(MODE_RETRY, '0, '0);
        // threshold above the slot count
        write_threshold('1);
        send_item(MODE_REPLAY, '0, '0);
        send_item(MODE_RETRY, '0, '0);
    endtask

    // one session: optional threshold change, ascending load pass, records,
    // replay chains, then a few arbitrary transactions
    task automatic run_log_round();
        int n, k, idx, chains;
        logic [EPOCH_W-1:0] ep;
        round_no++;
        if (round_no % 4 == 0) begin
            stall_mode = 0;
            send_gaps  = 1'b0;
        end else begin
            stall_mode = $urandom_range(0, 2);
            send_gaps  = ($urandom_range(0, 3) != 0);
        end
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 5))
                0:       write_threshold('0);
                1:       write_threshold(11'd1);
                4:       write_threshold(11'd1023);
                5:       write_threshold(11'd1024);
                default: write_threshold((SLOT_BITS+1)'($urandom_range(0, marked_slots)));
            endcase
        end
        idx = $urandom_range(0, SLOT_CNT - 1);
        n   = $urandom_range(3, 30);
        for (k = 0; k < n && idx < SLOT_CNT; k++) begin
            case ($urandom_range(0, 9))
                0, 1:    ep = EMPTY_EPOCH;
                2:       ep = $urandom();
                3:       ep = epoch_base;
                default: begin
                    epoch_base = epoch_base + $urandom_range(1, 1000);
                    ep         = epoch_base;
                end
            endcase
            send_item(MODE_LOAD, SLOT_BITS'(idx), ep);
            idx += $urandom_range(1, 20);
        end
        n = $urandom_range(4, 30);
        for (k = 0; k < n; k++) begin
            send_item(MODE_RECORD, SLOT_BITS'($urandom()), $urandom());
        end
        chains = $urandom_range(1, 3);
        for (k = 0; k < chains; k++) begin
            send_item(MODE_REPLAY, SLOT_BITS'($urandom()), $urandom());
            repeat ($urandom_range(0, 8)) begin
                send_item(MODE_RETRY, SLOT_BITS'($urandom()), $urandom());
            end
        end
        repeat ($urandom_range(0, 5)) begin
            ep = ($urandom_range(0, 3) == 0) ? EMPTY_EPOCH : $urandom();
            send_item(MODE_W'($urandom_range(0, 3)), SLOT_BITS'($urandom()), ep);
        end
    endtask

    task automatic test_random_log(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count) begin
            run_log_round();
        end
    endtask

    // long output hold-off while the input keeps offering
    task automatic test_backpressure();
        drain_results();
        stall_mode   = 0;
        send_gaps    = 1'b0;
        hold_request = 1'b1;
        repeat (12) begin
            if ($urandom_range(0, 1) == 0) begin
                send_item(MODE_RECORD, SLOT_BITS'($urandom()), $urandom());
            end else begin
                send_item(MODE_LOAD, SLOT_BITS'($urandom()), $urandom());
            end
        end
        send_item(MODE_REPLAY, '0, '0);
        send_item(MODE_RETRY, '0, '0);
    endtask

    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        pat_cnt++;
        if (pat_cnt % 64 == 0) begin
            ready_pat = 8'($urandom()) | 8'h01;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ready_pat[pat_cnt % 8];
            endcase
        end
    end

    always @(posedge aclk) begin : result_check
        slot_result_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got.status     = m_status;
            got.slot       = m_slot;
            got.erase      = m_erase_needed;
            got.first_slot = m_sector_first_slot;
            got.count      = m_valid_count;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: unexpected transaction status %0d slot %0d at %0t",
                             got.status, got.slot, $time);
                end
            end else begin
                want = pending_results.pop_front();
                status_hits[want.status]++;
                if (want.erase) begin
                    erase_hits++;
                end
                if (got.status !== want.status || got.slot !== want.slot ||
                    got.erase !== want.erase || got.first_slot !== want.first_slot ||
                    got.count !== want.count) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR at %0t (exp/got): status %0d/%0d slot %0d/%0d",
                                 $time, want.status, got.status, want.slot, got.slot);
                        $display("  erase %0d/%0d first %0d/%0d count %0d/%0d",
                                 want.erase, got.erase, want.first_slot, got.first_slot,
                                 want.count, got.count);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("flash_log_slot_manager_core test failed");
            $finish;
        end
    end

    initial begin
        for (int s = 0; s < SLOT_CNT; s++) begin
            valid_marks[s] = 1'b0;
        end
        for (int k = 0; k < 8; k++) begin
            status_hits[k] = 0;
        end
        write_ptr    = '0;
        read_pos     = '0;
        marked_slots = 0;
        scan_used    = 0;
        top_epoch    = '0;
        replay_min   = 11'd1;
        epoch_base   = $urandom() >> $urandom_range(0, 31);
        stall_mode   = 0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_log();
        test_load_pass();
        test_record();
        test_replay();
        test_random_log(RANDOM_HALF);
        test_backpressure();
        test_random_log(RANDOM_HALF);

        drain_results();
        if (pending_results.size() != 0) begin
            mismatches++;
        end
        $display("Covered %0d transactions: %0d loads, %0d writes (%0d with erase), %0d reads",
                 items_sent, status_hits[STATUS_LOAD], status_hits[STATUS_WRITE], erase_hits,
                 status_hits[STATUS_READ]);
        $display("  %0d replays refused, %0d empty scans, %0d threshold writes, %0d errors",
                 status_hits[STATUS_BELOW], status_hits[STATUS_NONE], thresholds_used,
                 mismatches);
        if (mismatches == 0) begin
            $display("flash_log_slot_manager_core test passed");
        end else begin
            $display("flash_log_slot_manager_core test failed");
        end
        $finish;
    end

endmodule
